>>> design/hrf_pkg.sv
// ----------------------------------------------------------------------------
// HLL flux package
// Shared types, number format constants and saturating Q-format arithmetic
// used by the HLL flux pipeline and its divider and square-root units.
// ----------------------------------------------------------------------------
package hrf_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int GW = 19;
    localparam int AW = 2;
    localparam int MW = 2 * DW + 2;

    localparam int DIV_NB   = DW + 1 + FB;
    localparam int DIV_LAT  = DIV_NB + 2;
    localparam int SQ_W     = ((DW + FB) / 2) * 2;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int SQRT_LAT = SQ_STEPS + 2;

    typedef logic signed [DW-1:0] t_q;

    localparam t_q QMAX = t_q'({1'b0, {(DW-1){1'b1}}});
    localparam t_q QMIN = t_q'({1'b1, {(DW-1){1'b0}}});
    localparam t_q ONE  = t_q'(64'd1 << FB);

    localparam logic [GW-1:0] HEAT_RATIO_RESET = GW'(91750);
    localparam logic [AW-1:0] ADDR_HEAT_RATIO  = '0;

    typedef enum logic [1:0] {
        REG_LEFT  = 2'd0,
        REG_RIGHT = 2'd1,
        REG_HLL   = 2'd2
    } t_region;

    typedef struct packed {
        t_q left_density;
        t_q left_normal_momentum;
        t_q left_tangent_momentum;
        t_q left_energy;
        t_q right_density;
        t_q right_normal_momentum;
        t_q right_tangent_momentum;
        t_q right_energy;
    } t_in;

    typedef struct packed {
        t_q         mass_flux;
        t_q         normal_momentum_flux;
        t_q         tangent_momentum_flux;
        t_q         energy_flux;
        logic [1:0] flux_region;
        logic       invalid_state;
    } t_out;

    function automatic t_q q_sadd(t_q a, t_q b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            q_sadd = s[DW] ? QMIN : QMAX;
        end else begin
            q_sadd = t_q'(s[DW-1:0]);
        end
    endfunction

    function automatic t_q q_ssub(t_q a, t_q b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            q_ssub = s[DW] ? QMIN : QMAX;
        end else begin
            q_ssub = t_q'(s[DW-1:0]);
        end
    endfunction

    function automatic logic [DW:0] q_mag(t_q a);
        logic [DW:0] ext;
        ext = {a[DW-1], a};
        q_mag = ext[DW] ? (~ext + (DW+1)'(1)) : ext;
    endfunction

    function automatic t_q q_pack(logic neg, logic [MW-1:0] m);
        logic [MW-1:0] hi;
        hi = m >> (DW - 1);
        if (neg) begin
            if (hi > MW'(1) || (hi == MW'(1) && m[DW-2:0] != '0)) begin
                q_pack = QMIN;
            end else begin
                q_pack = t_q'(-m[DW-1:0]);
            end
        end else begin
            q_pack = (hi != '0) ? QMAX : t_q'(m[DW-1:0]);
        end
    endfunction

    function automatic t_q q_mul(t_q a, t_q b);
        logic [MW-1:0] p;
        p = MW'(q_mag(a)) * MW'(q_mag(b));
        q_mul = q_pack(a[DW-1] ^ b[DW-1], p >> FB);
    endfunction

    function automatic t_q q_half(t_q x);
        logic [DW:0] s;
        s = {x[DW-1], x} + (DW+1)'(x[DW-1]);
        q_half = t_q'(s[DW:1]);
    endfunction

endpackage

>>> design/hrf_dly.sv
// ----------------------------------------------------------------------------
// Alignment delay line
// Fixed-length register chain that keeps side values in step with the
// long arithmetic units of the pipeline.
// ----------------------------------------------------------------------------
module hrf_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    generate
        if (N == 0) begin : g_none
            assign o_d = i_d;
        end else begin : g_chain
            logic [W-1:0] r_sr [0:N-1];
            always_ff @(posedge i_clk) begin
                r_sr[0] <= i_d;
                for (int k = 1; k < N; k++) begin
                    r_sr[k] <= r_sr[k-1];
                end
            end
            assign o_d = r_sr[N-1];
        end
    endgenerate

endmodule

>>> design/hrf_div.sv
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Restoring division, one quotient bit per register stage, giving the
// truncated and saturated Q-format quotient of two signed values.
// ----------------------------------------------------------------------------
module hrf_div
    import hrf_pkg::*;
(
    input  logic i_clk,
    input  t_q   i_num,
    input  t_q   i_den,
    output t_q   o_quo
);

    logic [DW:0]       r_rem [0:DIV_NB];
    logic [DIV_NB-1:0] r_num [0:DIV_NB];
    logic [DIV_NB-1:0] r_q   [0:DIV_NB];
    logic [DW:0]       r_den [0:DIV_NB];
    logic              r_neg [0:DIV_NB];
    logic              r_dz  [0:DIV_NB];
    logic              r_an  [0:DIV_NB];
    logic              r_az  [0:DIV_NB];
    t_q                r_quo;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= DIV_NB'(q_mag(i_num)) << FB;
        r_q[0]   <= '0;
        r_den[0] <= q_mag(i_den);
        r_neg[0] <= i_num[DW-1] ^ i_den[DW-1];
        r_dz[0]  <= (i_den == '0);
        r_an[0]  <= i_num[DW-1];
        r_az[0]  <= (i_num == '0);
    end

    generate
        for (genvar k = 0; k < DIV_NB; k++) begin : g_stage
            logic [DW+1:0] t;
            logic          ge;
            logic [DW+1:0] d;
            assign t  = {r_rem[k], r_num[k][DIV_NB-1]};
            assign ge = (t >= {1'b0, r_den[k]});
            assign d  = t - {1'b0, r_den[k]};
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= ge ? d[DW:0] : t[DW:0];
                r_num[k+1] <= r_num[k] << 1;
                r_q[k+1]   <= {r_q[k][DIV_NB-2:0], ge};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_dz[k+1]  <= r_dz[k];
                r_an[k+1]  <= r_an[k];
                r_az[k+1]  <= r_az[k];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (r_dz[DIV_NB]) begin
            r_quo <= r_an[DIV_NB] ? QMIN : (r_az[DIV_NB] ? '0 : QMAX);
        end else begin
            r_quo <= q_pack(r_neg[DIV_NB], MW'(r_q[DIV_NB]));
        end
    end

    assign o_quo = r_quo;

endmodule

>>> design/hrf_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined fixed-point square root
// Digit-by-digit root, one result bit per register stage, giving the floor
// of the Q-format root; non-positive operands give zero.
// ----------------------------------------------------------------------------
module hrf_sqrt
    import hrf_pkg::*;
(
    input  logic i_clk,
    input  t_q   i_rad,
    output t_q   o_root
);

    localparam int RW = SQ_STEPS + 2;

    logic [SQ_W-1:0]     r_x    [0:SQ_STEPS];
    logic [RW-1:0]       r_rem  [0:SQ_STEPS];
    logic [SQ_STEPS-1:0] r_root [0:SQ_STEPS];
    t_q                  r_out;

    always_ff @(posedge i_clk) begin
        r_x[0]    <= (i_rad > 0) ? (SQ_W'(i_rad[DW-2:0]) << FB) : '0;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    generate
        for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
            logic [RW-1:0] t;
            logic [RW-1:0] trial;
            logic          ge;
            assign t     = {r_rem[k][RW-3:0], r_x[k][SQ_W-1:SQ_W-2]};
            assign trial = {r_root[k], 2'b01};
            assign ge    = (t >= trial);
            always_ff @(posedge i_clk) begin
                r_x[k+1]    <= r_x[k] << 2;
                r_rem[k+1]  <= ge ? (t - trial) : t;
                r_root[k+1] <= {r_root[k][SQ_STEPS-2:0], ge};
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_out <= t_q'(r_root[SQ_STEPS]);
    end

    assign o_root = r_out;

endmodule

>>> design/hll_riemann_flux_euler_2d.sv
// ----------------------------------------------------------------------------
// HLL Riemann flux for the 2D Euler equations
// Pipelined Q16.16 HLL flux from left and right face-normal states.
// ----------------------------------------------------------------------------
// Usage: an item is taken at a rising edge where start is high and busy is
// low. busy never rises, so one Riemann problem may enter on every cycle.
// Each result is shown on o_result for exactly one cycle while o_done is
// high; results leave in the order the items came in. The latency is set
// by the chain of four pipelined dividers (one quotient bit per stage)
// and one pipelined square root in series.
// The receiver cannot hold results off, so the pipeline never stalls.
// The ratio of specific heats is written over the APB port at byte address
// 0 and is only to be changed while no item is in flight. Reset empties the
// pipeline, drops any results still in flight and sets the ratio to 1.4.
// ----------------------------------------------------------------------------
module hll_riemann_flux_euler_2d
    import hrf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_in           i_item,
    output logic          o_done,
    output t_out          o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int PA = DIV_LAT;
    localparam int PB = PA + 1;
    localparam int PC = PB + 1;
    localparam int PD = PC + 1;
    localparam int PE = PD + 1;
    localparam int PF = PE + DIV_LAT;
    localparam int PG = PF + 1;
    localparam int PH = PG + 1;
    localparam int PI = PH + DIV_LAT;
    localparam int PJ = PI + 1;
    localparam int PK = PJ + SQRT_LAT;
    localparam int PL = PK + 1;
    localparam int PM = PL + 1;
    localparam int PN = PM + 1;
    localparam int PO = PN + 1;
    localparam int PP = PO + DIV_LAT;
    localparam int PQ = PP + 1;

    logic          accept;
    logic [GW-1:0] r_gamma;
    t_q            g;
    t_q            gm1;
    logic [PQ:0]   r_vld;
    t_in           r_in;

    t_q [1:0][3:0] st0, st_a, st_e, st_l;
    t_q [1:0]      e_a, e_c, e_d;
    t_q [1:0]      u_a, v_a, sq_raw, sq_a, u_b, v_b, u_d, u_k, sq_f;
    logic          inv0;

    t_q [1:0] r_b_ku, r_b_kv, r_b_f0, r_b_su, r_b_sv;
    t_q       r_b_den;
    t_q       den_e, den_h;
    t_q [1:0] r_c_kin, r_c_f1m, r_c_f2, r_c_nuv;
    t_q [1:0] nuv_e, f1m_d;
    t_q [1:0] r_d_p;
    t_q [1:0] r_e_gp, r_e_hn, r_e_f1, r_e_f3;
    t_q [1:0] c2_f, h_f, roe_f, c_raw, c_k;
    t_q [1:0] r_g_sh, r_g_sq;
    t_q       r_h_hn, r_h_ks, ks_i, hroe_i;
    t_q       r_j_c2, croe_k, uroe_k;
    logic [1:0] pneg_d, pneg_k, c2neg_f, c2neg_k;
    logic       c2rneg_k, inv0_k;

    t_q       l_a, l_b, l_c, l_d;
    t_q       r_l_sl, r_l_sr;
    logic     r_l_inv;

    t_q [1:0][3:0] flx_l, flx_p;
    t_q [1:0]      f0_l, f2_l, f1_l, f3_l;
    t_region       r_m_reg;
    logic          r_m_inv;
    t_q            r_m_prod, r_m_span, span_o;
    t_q [3:0]      r_m_du, r_m_tl, r_m_tr;
    t_q [3:0]      r_n_pd, r_n_n1, r_o_num, res_p;
    logic [2:0]    ri_m, ri_p;
    t_region       reg_p;
    t_out          r_out;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= HEAT_RATIO_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_HEAT_RATIO)) begin
            r_gamma <= pwdata[GW-1:0];
        end
    end

    assign prdata = (paddr == ADDR_HEAT_RATIO) ? 32'(r_gamma) : '0;
    assign g      = t_q'(r_gamma);
    assign gm1    = q_ssub(g, ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PQ-1:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    assign st0[0][0] = r_in.left_density;
    assign st0[0][1] = r_in.left_normal_momentum;
    assign st0[0][2] = r_in.left_tangent_momentum;
    assign st0[0][3] = r_in.left_energy;
    assign st0[1][0] = r_in.right_density;
    assign st0[1][1] = r_in.right_normal_momentum;
    assign st0[1][2] = r_in.right_tangent_momentum;
    assign st0[1][3] = r_in.right_energy;
    assign inv0      = (st0[0][0] <= 0) || (st0[1][0] <= 0);

    hrf_dly #(.W(8*DW), .N(PA))    u_dly_sta (.i_clk, .i_d(st0),  .o_d(st_a));
    hrf_dly #(.W(8*DW), .N(PE-PA)) u_dly_ste (.i_clk, .i_d(st_a), .o_d(st_e));
    hrf_dly #(.W(8*DW), .N(PL-PE)) u_dly_stl (.i_clk, .i_d(st_e), .o_d(st_l));
    hrf_dly #(.W(1),    .N(PK))    u_dly_inv (.i_clk, .i_d(inv0), .o_d(inv0_k));

    generate
        for (genvar s = 0; s < 2; s++) begin : g_side
            assign e_a[s] = st_a[s][3];
            hrf_div  u_div_u (.i_clk, .i_num(st0[s][1]), .i_den(st0[s][0]), .o_quo(u_a[s]));
            hrf_div  u_div_v (.i_clk, .i_num(st0[s][2]), .i_den(st0[s][0]), .o_quo(v_a[s]));
            hrf_sqrt u_sq_rho (.i_clk, .i_rad(st0[s][0]), .o_root(sq_raw[s]));
            hrf_div  u_div_c2 (.i_clk, .i_num(r_e_gp[s]), .i_den(st_e[s][0]),
                               .o_quo(c2_f[s]));
            hrf_div  u_div_h (.i_clk, .i_num(r_e_hn[s]), .i_den(st_e[s][0]),
                              .o_quo(h_f[s]));
            hrf_div  u_div_roe (.i_clk, .i_num(nuv_e[s]), .i_den(den_e), .o_quo(roe_f[s]));
            hrf_sqrt u_sq_c (.i_clk, .i_rad(c2_f[s]), .o_root(c_raw[s]));
            assign pneg_d[s]  = r_d_p[s][DW-1];
            assign c2neg_f[s] = c2_f[s][DW-1];
        end
    endgenerate

    hrf_dly #(.W(2*DW), .N(PA-SQRT_LAT)) u_dly_sq  (.i_clk, .i_d(sq_raw), .o_d(sq_a));
    hrf_dly #(.W(2*DW), .N(1))           u_dly_ub  (.i_clk, .i_d(u_a),    .o_d(u_b));
    hrf_dly #(.W(2*DW), .N(1))           u_dly_vb  (.i_clk, .i_d(v_a),    .o_d(v_b));
    hrf_dly #(.W(2*DW), .N(PD-PB))       u_dly_ud  (.i_clk, .i_d(u_b),    .o_d(u_d));
    hrf_dly #(.W(2*DW), .N(PK-PD))       u_dly_uk  (.i_clk, .i_d(u_d),    .o_d(u_k));
    hrf_dly #(.W(2*DW), .N(PF-PA))       u_dly_sqf (.i_clk, .i_d(sq_a),   .o_d(sq_f));
    hrf_dly #(.W(2*DW), .N(PC-PA))       u_dly_ec  (.i_clk, .i_d(e_a),    .o_d(e_c));
    hrf_dly #(.W(2*DW), .N(1))           u_dly_ed  (.i_clk, .i_d(e_c),    .o_d(e_d));

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            r_b_ku[s] <= q_mul(st_a[s][1], u_a[s]);
            r_b_kv[s] <= q_mul(st_a[s][2], v_a[s]);
            r_b_f0[s] <= q_mul(st_a[s][0], u_a[s]);
            r_b_su[s] <= q_mul(sq_a[s], u_a[s]);
            r_b_sv[s] <= q_mul(sq_a[s], v_a[s]);
        end
        r_b_den <= q_sadd(sq_a[0], sq_a[1]);
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            r_c_kin[s] <= q_half(q_sadd(r_b_ku[s], r_b_kv[s]));
            r_c_f1m[s] <= q_mul(r_b_f0[s], u_b[s]);
            r_c_f2[s]  <= q_mul(r_b_f0[s], v_b[s]);
        end
        r_c_nuv[0] <= q_sadd(r_b_su[0], r_b_su[1]);
        r_c_nuv[1] <= q_sadd(r_b_sv[0], r_b_sv[1]);
    end

    hrf_dly #(.W(DW),   .N(PE-PB)) u_dly_dene (.i_clk, .i_d(r_b_den), .o_d(den_e));
    hrf_dly #(.W(DW),   .N(PH-PE)) u_dly_denh (.i_clk, .i_d(den_e),   .o_d(den_h));
    hrf_dly #(.W(2*DW), .N(PE-PC)) u_dly_nuv  (.i_clk, .i_d(r_c_nuv), .o_d(nuv_e));
    hrf_dly #(.W(2*DW), .N(1))     u_dly_f1m  (.i_clk, .i_d(r_c_f1m), .o_d(f1m_d));

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            r_d_p[s] <= q_mul(gm1, q_ssub(e_c[s], r_c_kin[s]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            r_e_gp[s] <= q_mul(g, r_d_p[s]);
            r_e_hn[s] <= q_sadd(e_d[s], r_d_p[s]);
            r_e_f1[s] <= q_sadd(f1m_d[s], r_d_p[s]);
            r_e_f3[s] <= q_mul(u_d[s], q_sadd(e_d[s], r_d_p[s]));
        end
    end

    hrf_dly #(.W(2*DW), .N(PK-PF-SQRT_LAT)) u_dly_ck (.i_clk, .i_d(c_raw), .o_d(c_k));
    hrf_dly #(.W(2), .N(PK-PD)) u_dly_pneg  (.i_clk, .i_d(pneg_d),  .o_d(pneg_k));
    hrf_dly #(.W(2), .N(PK-PF)) u_dly_c2neg (.i_clk, .i_d(c2neg_f), .o_d(c2neg_k));
    hrf_dly #(.W(DW), .N(PK-PF)) u_dly_uroe (.i_clk, .i_d(roe_f[0]), .o_d(uroe_k));

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            r_g_sh[s] <= q_mul(sq_f[s], h_f[s]);
            r_g_sq[s] <= q_mul(roe_f[s], roe_f[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_hn <= q_sadd(r_g_sh[0], r_g_sh[1]);
        r_h_ks <= q_half(q_sadd(r_g_sq[0], r_g_sq[1]));
    end

    hrf_div u_div_hroe (.i_clk, .i_num(r_h_hn), .i_den(den_h), .o_quo(hroe_i));
    hrf_dly #(.W(DW), .N(PI-PH)) u_dly_ks (.i_clk, .i_d(r_h_ks), .o_d(ks_i));

    always_ff @(posedge i_clk) begin
        r_j_c2 <= q_mul(gm1, q_ssub(hroe_i, ks_i));
    end

    hrf_sqrt u_sq_croe (.i_clk, .i_rad(r_j_c2), .o_root(croe_k));
    hrf_dly #(.W(1), .N(PK-PJ)) u_dly_c2r (.i_clk, .i_d(r_j_c2[DW-1]), .o_d(c2rneg_k));

    assign l_a = q_ssub(u_k[0], c_k[0]);
    assign l_b = q_ssub(uroe_k, croe_k);
    assign l_c = q_sadd(u_k[1], c_k[1]);
    assign l_d = q_sadd(uroe_k, croe_k);

    always_ff @(posedge i_clk) begin
        r_l_sl  <= (l_a < l_b) ? l_a : l_b;
        r_l_sr  <= (l_c > l_d) ? l_c : l_d;
        r_l_inv <= inv0_k || (pneg_k != '0) || (c2neg_k != '0) || c2rneg_k;
    end

    hrf_dly #(.W(2*DW), .N(PL-PB)) u_dly_f0 (.i_clk, .i_d(r_b_f0), .o_d(f0_l));
    hrf_dly #(.W(2*DW), .N(PL-PC)) u_dly_f2 (.i_clk, .i_d(r_c_f2), .o_d(f2_l));
    hrf_dly #(.W(2*DW), .N(PL-PE)) u_dly_f1 (.i_clk, .i_d(r_e_f1), .o_d(f1_l));
    hrf_dly #(.W(2*DW), .N(PL-PE)) u_dly_f3 (.i_clk, .i_d(r_e_f3), .o_d(f3_l));

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            flx_l[s][0] = f0_l[s];
            flx_l[s][1] = f1_l[s];
            flx_l[s][2] = f2_l[s];
            flx_l[s][3] = f3_l[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_l_sl >= 0) begin
            r_m_reg <= REG_LEFT;
        end else if (r_l_sr <= 0) begin
            r_m_reg <= REG_RIGHT;
        end else begin
            r_m_reg <= REG_HLL;
        end
        r_m_inv  <= r_l_inv;
        r_m_prod <= q_mul(r_l_sr, r_l_sl);
        r_m_span <= q_ssub(r_l_sr, r_l_sl);
        for (int k = 0; k < 4; k++) begin
            r_m_du[k] <= q_ssub(st_l[1][k], st_l[0][k]);
            r_m_tl[k] <= q_mul(r_l_sr, flx_l[0][k]);
            r_m_tr[k] <= q_mul(r_l_sl, flx_l[1][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_n_pd[k]  <= q_mul(r_m_prod, r_m_du[k]);
            r_n_n1[k]  <= q_ssub(r_m_tl[k], r_m_tr[k]);
            r_o_num[k] <= q_sadd(r_n_n1[k], r_n_pd[k]);
        end
    end

    hrf_dly #(.W(DW), .N(PO-PM)) u_dly_span (.i_clk, .i_d(r_m_span), .o_d(span_o));

    generate
        for (genvar k = 0; k < 4; k++) begin : g_hll
            hrf_div u_div_res (.i_clk, .i_num(r_o_num[k]), .i_den(span_o), .o_quo(res_p[k]));
        end
    endgenerate

    assign ri_m = {r_m_inv, r_m_reg};
    hrf_dly #(.W(8*DW), .N(PP-PL)) u_dly_flx (.i_clk, .i_d(flx_l), .o_d(flx_p));
    hrf_dly #(.W(3),    .N(PP-PM)) u_dly_ri  (.i_clk, .i_d(ri_m),  .o_d(ri_p));
    assign reg_p = t_region'(ri_p[1:0]);

    always_ff @(posedge i_clk) begin
        if (ri_p[2]) begin
            r_out.mass_flux             <= '0;
            r_out.normal_momentum_flux  <= '0;
            r_out.tangent_momentum_flux <= '0;
            r_out.energy_flux           <= '0;
            r_out.flux_region           <= REG_LEFT;
            r_out.invalid_state         <= 1'b1;
        end else begin
            case (reg_p)
                REG_LEFT: begin
                    r_out.mass_flux             <= flx_p[0][0];
                    r_out.normal_momentum_flux  <= flx_p[0][1];
                    r_out.tangent_momentum_flux <= flx_p[0][2];
                    r_out.energy_flux           <= flx_p[0][3];
                end
                REG_RIGHT: begin
                    r_out.mass_flux             <= flx_p[1][0];
                    r_out.normal_momentum_flux  <= flx_p[1][1];
                    r_out.tangent_momentum_flux <= flx_p[1][2];
                    r_out.energy_flux           <= flx_p[1][3];
                end
                default: begin
                    r_out.mass_flux             <= res_p[0];
                    r_out.normal_momentum_flux  <= res_p[1];
                    r_out.tangent_momentum_flux <= res_p[2];
                    r_out.energy_flux           <= res_p[3];
                end
            endcase
            r_out.flux_region   <= reg_p;
            r_out.invalid_state <= 1'b0;
        end
    end

    assign o_done   = r_vld[PQ];
    assign o_result = r_out;

endmodule

>>> verif/tb_hll_riemann_flux_euler_2d.sv
// ----------------------------------------------------------------------------
// HLL flux pipeline testbench
// Drives face states into the HLL flux block, predicts each flux transfer
// with an independent fixed-point model and checks them in order.
// ----------------------------------------------------------------------------
module tb_hll_riemann_flux_euler_2d
    import hrf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 243;
    localparam int WATCHDOG   = 5000;
    localparam int RAND_ITEMS = 850;

    typedef logic signed [63:0] t_w;

    class flux_scoreboard;
        t_out pending[$];
        int   mismatches;
        logic [GW-1:0] gamma_q;

        function new();
            mismatches = 0;
            gamma_q = HEAT_RATIO_RESET;
        endfunction

        function t_w sat(logic signed [127:0] x);
            if (x > 128'sd2147483647) begin
                return 64'sd2147483647;
            end
            if (x < -128'sd2147483648) begin
                return -64'sd2147483648;
            end
            return t_w'(x);
        endfunction

        function t_w add(t_w a, t_w b);
            return sat(128'(a) + 128'(b));
        endfunction

        function t_w sub(t_w a, t_w b);
            return sat(128'(a) - 128'(b));
        endfunction

        // Product truncated toward zero.
        function t_w mul(t_w a, t_w b);
            logic signed [127:0] p;
            p = 128'(a) * 128'(b);
            if (p < 0) begin
                p = -((-p) >>> FB);
            end else begin
                p = p >>> FB;
            end
            return sat(p);
        endfunction

        function t_w div(t_w a, t_w b);
            logic signed [127:0] n;
            if (b == 0) begin
                return (a > 0) ? 64'sd2147483647 : ((a < 0) ? -64'sd2147483648 : 64'sd0);
            end
            n = 128'(a) <<< FB;
            return sat(n / 128'(b));
        endfunction

        function t_w root(t_w a);
            logic [127:0] x;
            logic [63:0] r;
            logic [63:0] c;
            if (a <= 0) begin
                return 0;
            end
            x = 128'(a) << FB;
            r = 0;
            for (int i = 40; i >= 0; i--) begin
                c = r | (64'd1 << i);
                if (128'(c) * 128'(c) <= x) begin
                    r = c;
                end
            end
            return sat(128'(r));
        endfunction

        function t_w press(t_w gm1, t_w ru, t_w rv, t_w e, t_w u, t_w v);
            t_w kin;
            kin = mul(t_w'(1 << (FB - 1)), add(mul(ru, u), mul(rv, v)));
            return mul(gm1, sub(e, kin));
        endfunction

        function void note_item(t_in it);
            t_out r;
            t_w ql[4], qr[4], fl[4], fr[4], res[4];
            t_w g, gm1, half, uL, vL, uR, vR, pL, pR, cL2, cR2, hL, hR;
            t_w sL, sR, den, uRoe, vRoe, hRoe, cRoe2, wl, wr, a, b, prod, span, num;
            logic [1:0] region;
            logic bad;
            ql = '{t_w'(it.left_density), t_w'(it.left_normal_momentum),
                   t_w'(it.left_tangent_momentum), t_w'(it.left_energy)};
            qr = '{t_w'(it.right_density), t_w'(it.right_normal_momentum),
                   t_w'(it.right_tangent_momentum), t_w'(it.right_energy)};
            res = '{0, 0, 0, 0};
            half = t_w'(1 << (FB - 1));
            g = sat(128'(gamma_q));
            gm1 = sub(g, t_w'(1 << FB));
            region = REG_LEFT;
            bad = 1'b0;
            if (ql[0] <= 0 || qr[0] <= 0) begin
                bad = 1'b1;
            end else begin
                uL = div(ql[1], ql[0]);
                vL = div(ql[2], ql[0]);
                uR = div(qr[1], qr[0]);
                vR = div(qr[2], qr[0]);
                pL = press(gm1, ql[1], ql[2], ql[3], uL, vL);
                pR = press(gm1, qr[1], qr[2], qr[3], uR, vR);
                cL2 = div(mul(g, pL), ql[0]);
                cR2 = div(mul(g, pR), qr[0]);
                hL = div(add(ql[3], pL), ql[0]);
                hR = div(add(qr[3], pR), qr[0]);
                sL = root(ql[0]);
                sR = root(qr[0]);
                den = add(sL, sR);
                uRoe = div(add(mul(sL, uL), mul(sR, uR)), den);
                vRoe = div(add(mul(sL, vL), mul(sR, vR)), den);
                hRoe = div(add(mul(sL, hL), mul(sR, hR)), den);
                cRoe2 = mul(gm1, sub(hRoe, mul(half,
                            add(mul(uRoe, uRoe), mul(vRoe, vRoe)))));
                if (pL < 0 || pR < 0 || cL2 < 0 || cR2 < 0 || cRoe2 < 0) begin
                    bad = 1'b1;
                end else begin
                    a = sub(uL, root(cL2));
                    b = sub(uRoe, root(cRoe2));
                    wl = (a < b) ? a : b;
                    a = add(uR, root(cR2));
                    b = add(uRoe, root(cRoe2));
                    wr = (a > b) ? a : b;
                    fl[0] = mul(ql[0], uL);
                    fl[1] = add(mul(fl[0], uL), pL);
                    fl[2] = mul(fl[0], vL);
                    fl[3] = mul(uL, add(ql[3], pL));
                    fr[0] = mul(qr[0], uR);
                    fr[1] = add(mul(fr[0], uR), pR);
                    fr[2] = mul(fr[0], vR);
                    fr[3] = mul(uR, add(qr[3], pR));
                    if (wl >= 0) begin
                        res = fl;
                    end else if (wr <= 0) begin
                        region = REG_RIGHT;
                        res = fr;
                    end else begin
                        region = REG_HLL;
                        prod = mul(wr, wl);
                        span = sub(wr, wl);
                        for (int k = 0; k < 4; k++) begin
                            num = sub(mul(wr, fl[k]), mul(wl, fr[k]));
                            num = add(num, mul(prod, sub(qr[k], ql[k])));
                            res[k] = div(num, span);
                        end
                    end
                end
            end
            if (bad) begin
                res = '{0, 0, 0, 0};
                region = REG_LEFT;
            end
            r.mass_flux = t_q'(res[0]);
            r.normal_momentum_flux = t_q'(res[1]);
            r.tangent_momentum_flux = t_q'(res[2]);
            r.energy_flux = t_q'(res[3]);
            r.flux_region = region;
            r.invalid_state = bad;
            pending.push_back(r);
        endfunction

        function void check_flux(t_out act);
            t_out exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected flux transfer %h.", act);
                end
                return;
            end
            exp_r = pending.pop_front();
            if (act !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Flux mismatch: expected m=%h n=%h t=%h e=%h r=%0d i=%0d",
                             exp_r.mass_flux, exp_r.normal_momentum_flux,
                             exp_r.tangent_momentum_flux, exp_r.energy_flux,
                             exp_r.flux_region, exp_r.invalid_state);
                    $display("              actual   m=%h n=%h t=%h e=%h r=%0d i=%0d",
                             act.mass_flux, act.normal_momentum_flux,
                             act.tangent_momentum_flux, act.energy_flux,
                             act.flux_region, act.invalid_state);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in i_item = '0;
    logic o_done;
    t_out o_result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    flux_scoreboard fluxes = new();
    int idle_cycles = 0;

    hll_riemann_flux_euler_2d uut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            fluxes.check_flux(o_result);
        end
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG) begin
            $display("FAIL hll_riemann_flux_euler_2d");
            $finish;
        end
    end

    task automatic write_gamma(logic [31:0] v);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_HEAT_RATIO;
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        fluxes.gamma_q = v[GW-1:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        while (fluxes.pending.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    // Keeps start high across back-to-back transfers.
    task automatic send_state(t_in it);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        fluxes.note_item(it);
        @(negedge i_clk);
    endtask

    function automatic t_q rnd_word();
        case ($urandom_range(0, 5))
            0: return QMAX;
            1: return QMIN;
            default: return t_q'($urandom());
        endcase
    endfunction

    // Physically sensible state: positive density, bounded momentum, positive energy.
    function automatic t_in rnd_face();
        t_in it;
        logic signed [31:0] rho, mu, mv, en;
        for (int s = 0; s < 2; s++) begin
            rho = $urandom_range(1 << 12, 8 << 16);
            mu = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            mv = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            en = $urandom_range(1 << 14, 40 << 16);
            if (s == 0) begin
                it.left_density = rho;
                it.left_normal_momentum = mu;
                it.left_tangent_momentum = mv;
                it.left_energy = en;
            end else begin
                it.right_density = rho;
                it.right_normal_momentum = mu;
                it.right_tangent_momentum = mv;
                it.right_energy = en;
            end
        end
        return it;
    endfunction

    function automatic t_in flow(int dir);
        t_in it;
        it = rnd_face();
        it.left_density = ONE;
        it.right_density = ONE;
        it.left_energy = 2 * ONE;
        it.right_energy = 2 * ONE;
        it.left_normal_momentum = dir * 10 * ONE;
        it.right_normal_momentum = dir * 10 * ONE;
        it.left_energy = 60 * ONE;
        it.right_energy = 60 * ONE;
        return it;
    endfunction

    initial begin
        t_in it;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_state(flow(1));
        send_state(flow(-1));
        it = rnd_face();
        it.right_density = 0;
        send_state(it);
        it = rnd_face();
        it.left_density = QMIN;
        send_state(it);
        it = rnd_face();
        it.left_energy = -ONE;
        send_state(it);
        send_state('1);
        send_state('0);
        send_state({8{QMAX}});
        send_state({8{QMIN}});
        it = {8{QMAX}};
        it.left_normal_momentum = QMIN;
        send_state(it);
        for (int k = 0; k < 8; k++) begin
            send_state(rnd_face());
        end
        start = 1'b0;
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_gamma(32'd65537);
                1: write_gamma(32'd262144);
                2: write_gamma($urandom_range(65537, 262144));
                3: write_gamma(32'h7FFFF);
                default: write_gamma(32'd91750);
            endcase
            for (int n = 0; n < RAND_ITEMS / 5; n++) begin
                if ($urandom_range(0, 9) < 8) begin
                    it = rnd_face();
                end else begin
                    it = {rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                          rnd_word(), rnd_word(), rnd_word(), rnd_word()};
                end
                send_state(it);
            end
            start = 1'b0;
            drain();
        end

        if (fluxes.mismatches == 0 && fluxes.pending.size() == 0) begin
            $display("PASS hll_riemann_flux_euler_2d");
        end else begin
            $display("FAIL hll_riemann_flux_euler_2d");
        end
        $finish;
    end
endmodule
